[hdl/wpts_pkg.sv]
// Package: shared constants, types and the weighted priority map for the thread scheduler
package wpts_pkg;
  localparam int ThreadSlots = 64;
  localparam int TidW = 6;
  localparam int MapLength = 15;
  localparam int MapW = 4;
  localparam int QueueCount = 5;
  localparam int MaxLaps = 2;

  localparam logic [2:0] KIND_ENQ = 3'd0;
  localparam logic [2:0] KIND_EXT = 3'd1;
  localparam logic [2:0] KIND_CHOOSE = 3'd2;
  localparam logic [2:0] KIND_SLEEP = 3'd3;
  localparam logic [2:0] KIND_TICK = 3'd4;

  typedef logic [TidW-1:0] tid_t;
  typedef logic [2:0] prio_t;

  typedef struct packed {
    logic [2:0] kind;
    tid_t thread_id;
    prio_t priority_req;
    logic [31:0] sleep_ticks;
  } in_word_t;

  typedef struct packed {
    tid_t chosen_thread;
    logic none_ready;
  } out_word_t;

  // datapath operation codes
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_ENQ_RD, OP_ENQ_WR, OP_EXT_RD, OP_EXT_WR, OP_TICK,
    OP_SLP_START, OP_SLP_WALK, OP_SLP_INS, OP_WAKE_CHK, OP_WAKE_DO,
    OP_MAP_STEP, OP_MAP_POP
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic valid_tid;
    logic slp_empty;
    logic walk_done;
    logic wake_go;
    logic pop_hit;
    logic laps_over;
  } stat_t;

  function automatic prio_t clamp_prio(input prio_t p);
    if (p == 3'd0) return 3'd1;
    if (p > 3'd5) return 3'd5;
    return p;
  endfunction

  function automatic prio_t weight_map(input logic [MapW-1:0] pos);
    case (pos)
      4'd0: return 3'd5;
      4'd1: return 3'd4;
      4'd2: return 3'd3;
      4'd3: return 3'd5;
      4'd4: return 3'd4;
      4'd5: return 3'd2;
      4'd6: return 3'd5;
      4'd7: return 3'd3;
      4'd8: return 3'd4;
      4'd9: return 3'd5;
      4'd10: return 3'd1;
      4'd11: return 3'd4;
      4'd12: return 3'd5;
      4'd13: return 3'd3;
      4'd14: return 3'd2;
      default: return 3'd5;
    endcase
  endfunction
endpackage

[hdl/wpts_if.sv]
// Interface: valid/ready channels carrying input and result words
interface wpts_in_if;
  logic valid;
  logic ready;
  wpts_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wpts_out_if;
  logic valid;
  logic ready;
  wpts_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/wpts_dp.sv]
// Datapath: link tables, list ends, clock, map position and the result register
module wpts_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wpts_pkg::cmd_t       cmd,
  input  wpts_pkg::in_word_t   in_word,
  output wpts_pkg::stat_t      stat,
  output wpts_pkg::out_word_t  res
);
  localparam int N = wpts_pkg::ThreadSlots;
  localparam int W = wpts_pkg::TidW;

  logic [W-1:0] nxt_mem [N];
  logic [W-1:0] prv_mem [N];
  logic [2:0]   pri_mem [N];
  logic [31:0]  wak_mem [N];

  logic [W-1:0] rh_r [wpts_pkg::QueueCount];
  logic [W-1:0] rt_r [wpts_pkg::QueueCount];
  logic [W-1:0] sh_r, st_r;
  logic [wpts_pkg::MapW-1:0] pos_r;
  logic [1:0]  laps_r;
  logic [31:0] tick_r;

  wpts_pkg::in_word_t w_r;
  logic [31:0] wt_r;
  logic [W-1:0] idx_r;
  logic [W:0]   steps_r;
  logic [W-1:0] rd_n_r, rd_p_r;
  logic [2:0]   rd_q_r;
  logic [31:0]  rd_wk_r;
  wpts_pkg::out_word_t res_r;

  logic [W-1:0] t_w, sh_wi;
  logic [2:0] mq_w, nq_w;
  logic [31:0] wt_w;
  logic [wpts_pkg::MapW-1:0] pos_inc;
  logic wrap;

  assign t_w = w_r.thread_id;
  assign sh_wi = sh_r;
  assign wt_w = tick_r + w_r.sleep_ticks;
  assign wrap = ({1'b0, pos_r} + 5'd1) >= 5'(wpts_pkg::MapLength);
  assign pos_inc = wrap ? '0 : pos_r + 1'b1;
  assign mq_w = wpts_pkg::weight_map(pos_r) - 3'd1;
  assign nq_w = wpts_pkg::weight_map(pos_inc) - 3'd1;

  assign stat.valid_tid = (w_r.thread_id != '0);
  assign stat.slp_empty = (sh_r == '0);
  assign stat.walk_done = (idx_r == sh_r) || !(rd_wk_r > wt_r) || (steps_r >= (W+1)'(N));
  assign stat.wake_go = (sh_r != '0) && (rd_wk_r <= tick_r) &&
                        (steps_r < (W+1)'(N));
  assign stat.pop_hit = (rh_r[mq_w] != '0);
  assign stat.laps_over = (laps_r > 2'(wpts_pkg::MaxLaps));
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wpts_pkg::QueueCount; i++) begin
        rh_r[i] <= '0;
        rt_r[i] <= '0;
      end
      sh_r <= '0;
      st_r <= '0;
      pos_r <= wpts_pkg::MapW'(wpts_pkg::MapLength);
      laps_r <= '0;
      tick_r <= '0;
      res_r <= '0;
    end else begin
      case (cmd.op)
        wpts_pkg::OP_LOAD: begin
          w_r <= in_word;
          res_r <= '0;
          steps_r <= '0;
          laps_r <= '0;
        end
        wpts_pkg::OP_TICK: tick_r <= tick_r + 32'd1;
        wpts_pkg::OP_ENQ_RD: begin
          pri_mem[t_w] <= wpts_pkg::clamp_prio(w_r.priority_req);
          rd_q_r <= wpts_pkg::clamp_prio(w_r.priority_req) - 3'd1;
        end
        wpts_pkg::OP_ENQ_WR: begin
          if (rh_r[rd_q_r] == '0) begin
            rh_r[rd_q_r] <= t_w;
            prv_mem[t_w] <= '0;
          end else begin
            nxt_mem[rt_r[rd_q_r]] <= t_w;
            prv_mem[t_w] <= rt_r[rd_q_r];
          end
          rt_r[rd_q_r] <= t_w;
          nxt_mem[t_w] <= '0;
        end
        wpts_pkg::OP_EXT_RD: begin
          rd_q_r <= wpts_pkg::clamp_prio(pri_mem[t_w]) - 3'd1;
          rd_p_r <= prv_mem[t_w];
          rd_n_r <= nxt_mem[t_w];
        end
        wpts_pkg::OP_EXT_WR: begin
          if (rd_p_r == '0) rh_r[rd_q_r] <= rd_n_r;
          else nxt_mem[rd_p_r] <= rd_n_r;
          if (rd_n_r == '0) rt_r[rd_q_r] <= rd_p_r;
          else prv_mem[rd_n_r] <= rd_p_r;
        end
        wpts_pkg::OP_SLP_START: begin
          wt_r <= wt_w;
          wak_mem[t_w] <= wt_w;
          idx_r <= st_r;
          // the tail may be the sleeper itself, whose time is written this cycle
          rd_wk_r <= (st_r == t_w) ? wt_w : wak_mem[st_r];
          rd_p_r <= prv_mem[st_r];
          rd_n_r <= nxt_mem[st_r];
          if (sh_r == '0) begin
            sh_r <= t_w;
            st_r <= t_w;
            prv_mem[t_w] <= '0;
            nxt_mem[t_w] <= '0;
          end
        end
        wpts_pkg::OP_SLP_WALK: begin
          idx_r <= rd_p_r;
          rd_wk_r <= wak_mem[rd_p_r];
          rd_p_r <= prv_mem[rd_p_r];
          rd_n_r <= nxt_mem[rd_p_r];
          steps_r <= steps_r + 1'b1;
        end
        wpts_pkg::OP_SLP_INS: begin
          if (idx_r == sh_r && rd_wk_r > wt_r) begin
            sh_r <= t_w;
            prv_mem[t_w] <= '0;
            nxt_mem[t_w] <= idx_r;
            prv_mem[idx_r] <= t_w;
          end else begin
            prv_mem[t_w] <= idx_r;
            nxt_mem[t_w] <= rd_n_r;
            nxt_mem[idx_r] <= t_w;
            if (idx_r == st_r) st_r <= t_w;
            else if (st_r != t_w) prv_mem[rd_n_r] <= t_w;
          end
        end
        wpts_pkg::OP_WAKE_CHK: begin
          rd_wk_r <= wak_mem[sh_wi];
          rd_q_r <= wpts_pkg::clamp_prio(pri_mem[sh_wi]) - 3'd1;
          rd_n_r <= nxt_mem[sh_wi];
        end
        wpts_pkg::OP_WAKE_DO: begin
          // pop sleep head, append to its ready queue
          if (sh_r == st_r) begin
            sh_r <= '0;
            st_r <= '0;
          end else begin
            sh_r <= rd_n_r;
            prv_mem[rd_n_r] <= '0;
          end
          if (rh_r[rd_q_r] == '0) begin
            rh_r[rd_q_r] <= sh_r;
            prv_mem[sh_wi] <= '0;
          end else begin
            nxt_mem[rt_r[rd_q_r]] <= sh_r;
            prv_mem[sh_wi] <= rt_r[rd_q_r];
          end
          rt_r[rd_q_r] <= sh_r;
          nxt_mem[sh_wi] <= '0;
          steps_r <= steps_r + 1'b1;
        end
        wpts_pkg::OP_MAP_STEP: begin
          pos_r <= pos_inc;
          if (wrap) laps_r <= laps_r + 2'd1;
          rd_n_r <= nxt_mem[rh_r[nq_w]];
        end
        wpts_pkg::OP_MAP_POP: begin
          if (rh_r[mq_w] != '0) begin
            res_r.chosen_thread <= rh_r[mq_w];
            res_r.none_ready <= 1'b0;
            if (rh_r[mq_w] == rt_r[mq_w]) begin
              rh_r[mq_w] <= '0;
              rt_r[mq_w] <= '0;
            end else begin
              rh_r[mq_w] <= rd_n_r;
              prv_mem[rd_n_r] <= '0;
            end
          end else begin
            res_r.chosen_thread <= '0;
            res_r.none_ready <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

[hdl/wpts_ctrl.sv]
// Controller: sequences datapath operations for each input word
module wpts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  wpts_in_if.sink             in_ch,
  input  logic                out_ready,
  output logic                out_valid,
  input  wpts_pkg::stat_t     stat,
  output wpts_pkg::cmd_t      cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_ENQ, S_EXT, S_WRD, S_WALK, S_INS, S_WAKE, S_STEP, S_POP, S_OUT
  } state_t;

  state_t state_r;
  logic [2:0] kind_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd.op = wpts_pkg::OP_NONE;
    case (state_r)
      S_IDLE: if (in_ch.valid) cmd.op = wpts_pkg::OP_LOAD;
      S_DEC: begin
        case (kind_r)
          wpts_pkg::KIND_ENQ: if (stat.valid_tid) cmd.op = wpts_pkg::OP_ENQ_RD;
          wpts_pkg::KIND_EXT: if (stat.valid_tid) cmd.op = wpts_pkg::OP_EXT_RD;
          wpts_pkg::KIND_SLEEP: if (stat.valid_tid) cmd.op = wpts_pkg::OP_SLP_START;
          wpts_pkg::KIND_TICK: cmd.op = wpts_pkg::OP_TICK;
          default: ;
        endcase
      end
      S_ENQ: cmd.op = wpts_pkg::OP_ENQ_WR;
      S_EXT: cmd.op = wpts_pkg::OP_EXT_WR;
      S_WALK: if (!stat.walk_done) cmd.op = wpts_pkg::OP_SLP_WALK;
      S_INS: cmd.op = wpts_pkg::OP_SLP_INS;
      S_WRD: cmd.op = wpts_pkg::OP_WAKE_CHK;
      S_WAKE: if (stat.wake_go) cmd.op = wpts_pkg::OP_WAKE_DO;
      S_STEP: cmd.op = wpts_pkg::OP_MAP_STEP;
      S_POP: if (stat.pop_hit || stat.laps_over) cmd.op = wpts_pkg::OP_MAP_POP;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          kind_r <= in_ch.data.kind;
          state_r <= S_DEC;
        end
        S_DEC: begin
          case (kind_r)
            wpts_pkg::KIND_ENQ: state_r <= stat.valid_tid ? S_ENQ : S_OUT;
            wpts_pkg::KIND_EXT: state_r <= stat.valid_tid ? S_EXT : S_OUT;
            wpts_pkg::KIND_SLEEP:
              state_r <= (stat.valid_tid && !stat.slp_empty) ? S_WALK : S_OUT;
            wpts_pkg::KIND_CHOOSE: state_r <= S_WRD;
            default: state_r <= S_OUT;
          endcase
        end
        S_ENQ, S_EXT, S_INS: state_r <= S_OUT;
        S_WALK: if (stat.walk_done) state_r <= S_INS;
        S_WRD: state_r <= S_WAKE;
        S_WAKE: state_r <= stat.wake_go ? S_WRD : S_STEP;
        S_STEP: state_r <= S_POP;
        S_POP: state_r <= (stat.pop_hit || stat.laps_over) ? S_OUT : S_STEP;
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[hdl/weighted_priority_thread_scheduler.sv]
// Top level: weighted priority thread scheduler
//  channel | dir | handshake            | payload
//  in_     | in  | in_valid / in_ready  | kind, thread_id, priority_req, sleep_ticks
//  out_    | out | out_valid / out_ready| chosen_thread, none_ready
// One word at a time. Every word, ticks and ignored words too, gets a result; sleep into a
// non-empty list walks entries from the tail; choose wakes due sleepers, then takes map
// steps (up to 45 steps).
// Synchronous active-low reset empties all queues, no clearing pass.
// The result register holds until out_ready; no new word is taken meanwhile.
module weighted_priority_thread_scheduler (
  input  logic clk,
  input  logic rst_n,
  wpts_in_if.sink   in_ch,
  wpts_out_if.source out_ch
);
  wpts_pkg::cmd_t cmd;
  wpts_pkg::stat_t stat;
  wpts_pkg::out_word_t res;

  wpts_ctrl u_ctrl (
    .clk, .rst_n, .in_ch, .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .stat, .cmd
  );
  wpts_dp u_dp (
    .clk, .rst_n, .cmd, .in_word(in_ch.data), .stat, .res
  );
  assign out_ch.data = res;
endmodule

[hdl/wpts_chk.sv]
// Checker: port-level assertions for the scheduler, bound to the top level
module wpts_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [5:0] chosen_thread,
  input logic none_ready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(chosen_thread))
    else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && none_ready |-> chosen_thread == 6'd0) else $error("none with thread");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind weighted_priority_thread_scheduler wpts_chk u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .chosen_thread(out_ch.data.chosen_thread), .none_ready(out_ch.data.none_ready)
);

[test/wpts_checker.sv]
// Checker: watches both channels, predicts each scheduler answer and compares it
`timescale 1ns / 100ps
module wpts_checker
  import wpts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  wpts_in_if   in_mon,
  wpts_out_if  out_mon,
  output int   errors,
  output int   pending
);
  localparam int Slots = 64;
  localparam logic [2:0] PickMap [15] = '{3'd5, 3'd4, 3'd3, 3'd5, 3'd4, 3'd2, 3'd5, 3'd3,
                                          3'd4, 3'd5, 3'd1, 3'd4, 3'd5, 3'd3, 3'd2};

  tid_t        link_fwd [Slots];
  tid_t        link_back [Slots];
  prio_t       level_of [Slots];
  logic [31:0] wake_at [Slots];
  tid_t        rq_head [5];
  tid_t        rq_tail [5];
  tid_t        nap_head, nap_tail;
  int          map_pos;
  logic [31:0] ticks_now;
  out_word_t   expected_picks [$];

  function automatic prio_t fix_level(prio_t p);
    if (p == 3'd0) return 3'd1;
    if (p > 3'd5) return 3'd5;
    return p;
  endfunction

  function automatic void rq_append(tid_t t);
    int q;
    q = fix_level(level_of[t]) - 1;
    if (rq_head[q] == 0) begin
      rq_head[q] = t;
      rq_tail[q] = t;
      link_back[t] = 0;
    end else begin
      link_fwd[rq_tail[q]] = t;
      link_back[t] = rq_tail[q];
      rq_tail[q] = t;
    end
    link_fwd[t] = 0;
  endfunction

  function automatic tid_t rq_pop(int q);
    tid_t t;
    t = rq_head[q];
    if (t == 0) return 0;
    if (t == rq_tail[q]) begin
      rq_head[q] = 0;
      rq_tail[q] = 0;
    end else begin
      rq_head[q] = link_fwd[t];
      link_back[rq_head[q]] = 0;
    end
    return t;
  endfunction

  function automatic void rq_unlink(tid_t t);
    int q;
    tid_t p, n;
    q = fix_level(level_of[t]) - 1;
    p = link_back[t];
    n = link_fwd[t];
    if (p == 0) rq_head[q] = n; else link_fwd[p] = n;
    if (n == 0) rq_tail[q] = p; else link_back[n] = p;
  endfunction

  function automatic void nap_insert(tid_t t, logic [31:0] dt);
    logic [31:0] wt;
    tid_t idx, nx;
    int steps;
    wt = ticks_now + dt;
    steps = 0;
    wake_at[t] = wt;
    if (nap_head == 0) begin
      nap_head = t;
      nap_tail = t;
      link_back[t] = 0;
      link_fwd[t] = 0;
      return;
    end
    idx = nap_tail;
    while (idx != nap_head && wake_at[idx] > wt && steps < Slots) begin
      idx = link_back[idx];
      steps++;
    end
    if (idx == nap_head && wake_at[nap_head] > wt) begin
      nap_head = t;
      link_back[t] = 0;
      link_fwd[t] = idx;
      link_back[idx] = t;
    end else begin
      if (idx == nap_tail) nap_tail = t;
      link_back[t] = idx;
      nx = link_fwd[idx];
      link_fwd[t] = nx;
      link_fwd[idx] = t;
      if (nap_tail != t) link_back[nx] = t;
    end
  endfunction

  function automatic void wake_due();
    int steps;
    tid_t t;
    steps = 0;
    while (nap_head != 0 && wake_at[nap_head] <= ticks_now && steps < Slots) begin
      t = nap_head;
      if (t == nap_tail) begin
        nap_head = 0;
        nap_tail = 0;
      end else begin
        nap_head = link_fwd[t];
        link_back[nap_head] = 0;
      end
      rq_append(t);
      steps++;
    end
  endfunction

  function automatic tid_t pick_next();
    int laps;
    tid_t t;
    laps = 0;
    forever begin
      map_pos++;
      if (map_pos >= 15) begin
        map_pos = 0;
        laps++;
      end
      t = rq_pop(PickMap[map_pos % 15] - 1);
      if (t != 0) return t;
      if (laps > 2) return 0;
    end
  endfunction

  function automatic out_word_t predict_pick(in_word_t w);
    out_word_t r;
    logic ok;
    r = '0;
    ok = (w.thread_id != 0);
    case (w.kind)
      KIND_ENQ: if (ok) begin
        level_of[w.thread_id] = fix_level(w.priority_req);
        rq_append(w.thread_id);
      end
      KIND_EXT: if (ok) rq_unlink(w.thread_id);
      KIND_CHOOSE: begin
        wake_due();
        r.chosen_thread = pick_next();
        r.none_ready = (r.chosen_thread == 0);
      end
      KIND_SLEEP: if (ok) nap_insert(w.thread_id, w.sleep_ticks);
      KIND_TICK: ticks_now = ticks_now + 1;
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < Slots; i++) begin
        link_fwd[i] = 0;
        link_back[i] = 0;
        level_of[i] = 0;
        wake_at[i] = 0;
      end
      for (int q = 0; q < 5; q++) begin
        rq_head[q] = 0;
        rq_tail[q] = 0;
      end
      nap_head = 0;
      nap_tail = 0;
      map_pos = 15;
      ticks_now = 0;
      expected_picks.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) expected_picks.push_back(predict_pick(in_mon.data));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_picks.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = expected_picks.pop_front();
          if (out_mon.data.chosen_thread !== want.chosen_thread)
            report_mismatch("chosen_thread", out_mon.data.chosen_thread, want.chosen_thread);
          if (out_mon.data.none_ready !== want.none_ready)
            report_mismatch("none_ready", out_mon.data.none_ready, want.none_ready);
        end
      end
    end
    pending = expected_picks.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end
endmodule

[test/testbench.sv]
// Testbench top: stimulus, output stalls, watchdog and verdict for the thread scheduler
`timescale 1ns / 100ps
module testbench;
  import wpts_pkg::*;

  localparam int RandomWords = 800;
  localparam int StallLimit = 4000;

  logic clk;
  logic rst_n;
  int   errors, pending;
  int   idle_cycles;
  int   kind_seen [8];
  int   picks, empties;
  logic hold_req, steady;
  int   thread_loc [64];
  logic ever_queued [64];

  wpts_in_if  in_ch ();
  wpts_out_if out_ch ();

  weighted_priority_thread_scheduler dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  wpts_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // thread_loc: 0 free, 1 ready, 2 asleep (as seen from stimulus)
  task automatic send_word(logic [2:0] k, tid_t t, prio_t p, logic [31:0] dt);
    in_word_t w;
    int gap;
    w.kind = k;
    w.thread_id = t;
    w.priority_req = p;
    w.sleep_ticks = dt;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    kind_seen[k]++;
    if (t != 0) begin
      if (k == KIND_ENQ) begin
        thread_loc[t] = 1;
        ever_queued[t] = 1;
      end else if (k == KIND_EXT) begin
        thread_loc[t] = 0;
      end else if (k == KIND_SLEEP) begin
        thread_loc[t] = 2;
      end
    end
  endtask

  function automatic tid_t find_thread(int loc, logic need_queued);
    tid_t t;
    for (int i = 0; i < 12; i++) begin
      t = tid_t'($urandom_range(1, 63));
      if (thread_loc[t] == loc && (!need_queued || ever_queued[t])) return t;
    end
    return 0;
  endfunction

  function automatic logic [31:0] pick_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 4);
    if (r < 90) return $urandom_range(0, 30);
    return $urandom;
  endfunction

  task automatic random_word();
    int r;
    tid_t t, any_t;
    prio_t any_p;
    logic [31:0] any_d;
    r = $urandom_range(0, 99);
    any_t = tid_t'($urandom);
    any_p = prio_t'($urandom);
    any_d = $urandom;
    if (r < 30) begin
      t = find_thread(0, 1'b0);
      if (t == 0) send_word(KIND_TICK, any_t, any_p, any_d);
      else send_word(KIND_ENQ, t, prio_t'($urandom_range(0, 7)), any_d);
    end else if (r < 40) begin
      t = find_thread(1, 1'b1);
      if (t == 0) send_word(KIND_TICK, any_t, any_p, any_d);
      else send_word(KIND_EXT, t, any_p, any_d);
    end else if (r < 65) begin
      send_word(KIND_CHOOSE, any_t, any_p, any_d);
    end else if (r < 80) begin
      t = find_thread(0, 1'b1);
      if (t == 0) send_word(KIND_TICK, any_t, any_p, any_d);
      else send_word(KIND_SLEEP, t, any_p, pick_ticks());
    end else if (r < 95) begin
      send_word(KIND_TICK, any_t, any_p, any_d);
    end else if (r < 98) begin
      send_word(3'($urandom_range(5, 7)), any_t, any_p, any_d);
    end else begin
      send_word($urandom_range(0, 3) == 1 ? KIND_EXT : KIND_ENQ, 0, any_p, any_d);
    end
  endtask

  // result side stalls
  initial begin
    int gap, burst;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        burst = $urandom_range(1, 8);
        out_ch.ready <= 1'b1;
        repeat (burst) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      if (out_ch.data.chosen_thread != 0) begin
        thread_loc[out_ch.data.chosen_thread] = 0;
        picks++;
      end
      if (out_ch.data.none_ready) empties++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    hold_req = 1'b0;
    steady = 1'b0;
    idle_cycles = 0;
    picks = 0;
    empties = 0;
    for (int i = 0; i < 8; i++) kind_seen[i] = 0;
    for (int i = 0; i < 64; i++) begin
      thread_loc[i] = 0;
      ever_queued[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty choose, priority clamps, id extremes, wrap sleeps, bad kinds
    send_word(KIND_CHOOSE, 0, 0, 0);
    send_word(KIND_ENQ, 63, 0, 32'hFFFF_FFFF);
    send_word(KIND_ENQ, 1, 7, 0);
    send_word(KIND_ENQ, 2, 6, 0);
    send_word(KIND_ENQ, 42, 3, 0);
    send_word(KIND_ENQ, 21, 2, 0);
    send_word(KIND_ENQ, 0, 3, 0);
    send_word(KIND_EXT, 0, 0, 0);
    send_word(KIND_EXT, 2, 0, 0);
    send_word(KIND_CHOOSE, 63, 7, 32'hFFFF_FFFF);
    send_word(KIND_CHOOSE, 0, 0, 0);
    send_word(KIND_EXT, 42, 0, 0);
    send_word(KIND_SLEEP, 2, 0, 32'hFFFF_FFFF);
    send_word(KIND_SLEEP, 42, 0, 3);
    send_word(KIND_SLEEP, 0, 0, 1);
    send_word(KIND_TICK, 63, 7, 32'hFFFF_FFFF);
    send_word(KIND_SLEEP, 2, 0, 2);
    send_word(5, 1, 1, 1);
    send_word(6, 62, 4, 32'h5555_5555);
    send_word(7, 63, 7, 32'hAAAA_AAAA);
    repeat (4) send_word(KIND_TICK, 0, 0, 0);
    repeat (4) send_word(KIND_CHOOSE, 0, 0, 0);

    for (int n = 0; n < RandomWords; n++) begin
      if (n == 300) hold_req = 1'b1;
      if (n == 500) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      steady = (n >= 600 && n < 700);
      random_word();
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("words: %0d enqueue, %0d extract, %0d choose, %0d sleep, %0d tick, %0d other",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5] + kind_seen[6] + kind_seen[7]);
    $display("choose results: %0d threads picked, %0d with nothing ready", picks, empties);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
